FILE: design/jsa_pkg.sv
// Shared constants and register codes for the four-point Jacobi stencil block.
package jsa_pkg;

  localparam int MAX_COLUMNS_DEF = 1024;
  localparam int MAX_ROWS_DEF    = 1024;
  localparam int SAMPLE_BITS_DEF = 32;

  // configuration register widths and reset values
  localparam int GRID_BITS   = 11;
  localparam int BOUND_BITS  = 10;
  localparam int INDEX_BITS  = 10;
  localparam int CFG_IDX_BITS = 3;

  localparam logic [GRID_BITS-1:0]  GRID_WIDTH_RST  = 11'd1024;
  localparam logic [GRID_BITS-1:0]  GRID_HEIGHT_RST = 11'd1024;
  localparam logic [BOUND_BITS-1:0] ROW_FIRST_RST   = 10'd1;
  localparam logic [BOUND_BITS-1:0] ROW_END_RST     = 10'd1023;
  localparam logic [BOUND_BITS-1:0] COL_FIRST_RST   = 10'd1;
  localparam logic [BOUND_BITS-1:0] COL_END_RST     = 10'd1023;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_GRID_WIDTH  = 3'd0,
    REG_GRID_HEIGHT = 3'd1,
    REG_ROW_FIRST   = 3'd2,
    REG_ROW_END     = 3'd3,
    REG_COL_FIRST   = 3'd4,
    REG_COL_END     = 3'd5
  } cfg_reg_t;

endpackage

FILE: design/jacobi_stencil_average_top.sv
// Four-point Jacobi stencil over a raster stream, with line stores and output staging.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------------
//  in_     | in  | in_tvalid/in_tready  | in_tdata: sample
//  out_    | out | out_tvalid/out_tready| out_tdata: average, row_index, col_index;
//          |     |                      | out_tlast: last_point
//  cfg_    | in  | cfg_valid/cfg_ready  | cfg_index: register, cfg_data: value
//
// One word is taken per clock while in_tready is high; a result leaves through the operand
// and sum registers. The line stores are read in the cycle before the next word, so the store
// port sets the rate at one word a cycle.
// After reset a clearing pass over every column address zeroes both line stores; in_tready
// stays low meanwhile, configuration writes are taken as ever.
// Stalls on out_tready back up through the two register stages to in_tready.
module jacobi_stencil_average_top #(
  parameter int MAX_COLUMNS = jsa_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = jsa_pkg::MAX_ROWS_DEF,
  parameter int SAMPLE_BITS = jsa_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // in_tdata: [SAMPLE_BITS-1:0] sample, zero fill above
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      in_tdata,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // out_tdata: average, row_index (10), col_index (10), zero fill above
  output logic [((SAMPLE_BITS+20+7)/8)*8-1:0]   out_tdata,
  output logic                                  out_tlast,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [jsa_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [jsa_pkg::GRID_BITS-1:0]         cfg_data
);
  import jsa_pkg::*;

  localparam int SB     = SAMPLE_BITS;
  localparam int OUT_W  = ((SB + 20 + 7) / 8) * 8;
  localparam int CW     = $clog2(MAX_COLUMNS);
  localparam int RW     = $clog2(MAX_ROWS);
  localparam int WW     = $clog2(MAX_COLUMNS + 1);
  localparam int HW     = $clog2(MAX_ROWS + 1);
  localparam int XW0    = (WW > HW) ? WW : HW;
  // common compare width, one spare bit so nothing wraps
  localparam int XW     = ((XW0 > GRID_BITS) ? XW0 : GRID_BITS) + 1;
  localparam int SUMW   = SB + 2;

  localparam logic [XW-1:0] MAXC_X = XW'(MAX_COLUMNS);
  localparam logic [XW-1:0] MAXR_X = XW'(MAX_ROWS);
  localparam logic [XW-1:0] THREE_X = XW'(3);
  localparam logic [XW-1:0] ONE_X   = XW'(1);
  localparam logic [CW-1:0] LAST_COL = CW'(MAX_COLUMNS - 1);

  // ---------------- configuration registers ----------------
  logic [GRID_BITS-1:0]  grid_width_r, grid_height_r;
  logic [BOUND_BITS-1:0] row_first_r, row_end_r, col_first_r, col_end_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= GRID_WIDTH_RST;
      grid_height_r <= GRID_HEIGHT_RST;
      row_first_r   <= ROW_FIRST_RST;
      row_end_r     <= ROW_END_RST;
      col_first_r   <= COL_FIRST_RST;
      col_end_r     <= COL_END_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GRID_WIDTH:  grid_width_r  <= cfg_data;
        REG_GRID_HEIGHT: grid_height_r <= cfg_data;
        REG_ROW_FIRST:   row_first_r   <= cfg_data[BOUND_BITS-1:0];
        REG_ROW_END:     row_end_r     <= cfg_data[BOUND_BITS-1:0];
        REG_COL_FIRST:   col_first_r   <= cfg_data[BOUND_BITS-1:0];
        REG_COL_END:     col_end_r     <= cfg_data[BOUND_BITS-1:0];
        default: ;  // unknown index: dropped
      endcase
    end
  end

  // effective grid size and window bounds
  logic [XW-1:0] gw_x, gh_x, w_x, h_x, r0_x, r1_x, c0_x, c1_x;
  logic [XW-1:0] rf_x, re_x, cf_x, ce_x;

  always_comb begin
    gw_x = XW'(grid_width_r);
    gh_x = XW'(grid_height_r);
    rf_x = XW'(row_first_r);
    re_x = XW'(row_end_r);
    cf_x = XW'(col_first_r);
    ce_x = XW'(col_end_r);
    w_x  = (gw_x < THREE_X) ? THREE_X : ((gw_x > MAXC_X) ? MAXC_X : gw_x);
    h_x  = (gh_x < THREE_X) ? THREE_X : ((gh_x > MAXR_X) ? MAXR_X : gh_x);
    r0_x = (rf_x < ONE_X) ? ONE_X : rf_x;
    r1_x = (re_x < h_x - ONE_X) ? re_x : h_x - ONE_X;
    c0_x = (cf_x < ONE_X) ? ONE_X : cf_x;
    c1_x = (ce_x < w_x - ONE_X) ? ce_x : w_x - ONE_X;
  end

  // ---------------- clearing pass ----------------
  logic          clear_busy_r;
  logic [CW-1:0] clear_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_busy_r <= 1'b1;
      clear_addr_r <= '0;
    end else if (clear_busy_r) begin
      clear_addr_r <= clear_addr_r + 1'b1;
      if (clear_addr_r == LAST_COL) clear_busy_r <= 1'b0;
    end
  end

  // ---------------- handshake ----------------
  logic s1_valid_r, out_valid_r;
  logic s1_adv, s1_load, accept;

  assign s1_adv    = !out_valid_r || out_tready;
  assign s1_load   = !s1_valid_r || s1_adv;
  assign in_tready = !clear_busy_r && s1_load;
  assign accept    = in_tvalid && in_tready;

  // ---------------- position counters ----------------
  logic [CW-1:0] col_r, col_nxt, col_sel;
  logic [RW-1:0] row_r, row_nxt;
  logic [XW-1:0] col_x, row_x, col_inc_x, row_inc_x, row_m1_x;

  always_comb begin
    col_x     = XW'(col_r);
    row_x     = XW'(row_r);
    col_inc_x = col_x + ONE_X;
    row_inc_x = row_x + ONE_X;
    row_m1_x  = row_x - ONE_X;
    col_nxt   = col_r + 1'b1;
    row_nxt   = row_r;
    if (col_inc_x >= w_x) begin
      col_nxt = '0;
      row_nxt = (row_inc_x >= h_x) ? '0 : row_r + 1'b1;
    end else if (row_x >= h_x) begin
      row_nxt = '0;  // grid shrank under the counter
    end
    col_sel = accept ? col_nxt : col_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------- line stores ----------------
  // read ahead by the next column address: older data matches the current column, newer data the one after
  logic [SB-1:0] older_mem [MAX_COLUMNS];
  logic [SB-1:0] newer_mem [MAX_COLUMNS];
  logic [SB-1:0] older_rd_r, newer_rd_r, newer0_r;
  logic [CW:0]   newer_addr, newer_addr_r;
  logic [CW-1:0] newer_idx, wr_addr;
  logic [SB-1:0] older_wd, newer_wd;
  logic          mem_we;

  logic [SB-1:0] sample, win1_r, win2_r;
  logic [SB-1:0] win0_new, win1_new, win2_new;
  logic          first_col, newer_ok;

  assign newer_addr = {1'b0, col_sel} + 1'b1;
  assign newer_idx  = (newer_addr < (CW + 1)'(MAX_COLUMNS)) ? newer_addr[CW-1:0] : '0;
  assign mem_we     = clear_busy_r || accept;
  assign wr_addr    = clear_busy_r ? clear_addr_r : col_r;
  assign older_wd   = clear_busy_r ? '0 : win1_new;
  assign newer_wd   = clear_busy_r ? '0 : sample;

  always_ff @(posedge clk) begin
    if (mem_we) older_mem[wr_addr] <= older_wd;
    older_rd_r <= older_mem[col_sel];
  end

  always_ff @(posedge clk) begin
    if (mem_we) newer_mem[wr_addr] <= newer_wd;
    newer_rd_r   <= newer_mem[newer_idx];
    newer_addr_r <= newer_addr;
  end

  // middle-row window; entry zero of the newer row is kept in a register
  assign sample    = in_tdata[SB-1:0];
  assign first_col = (col_r == '0);
  assign newer_ok  = (XW'(newer_addr_r) < w_x);
  assign win0_new  = first_col ? '0 : win1_r;
  assign win1_new  = first_col ? newer0_r : win2_r;
  assign win2_new  = newer_ok ? newer_rd_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win1_r   <= '0;
      win2_r   <= '0;
      newer0_r <= '0;
    end else if (accept) begin
      win1_r <= win1_new;
      win2_r <= win2_new;
      if (first_col) newer0_r <= sample;
    end
  end

  // ---------------- window test ----------------
  logic hit, last_hit;

  assign hit = (row_x >= ONE_X) && (row_m1_x >= r0_x) && (row_m1_x < r1_x)
               && (col_x >= c0_x) && (col_x < c1_x);
  assign last_hit = (row_x == r1_x) && (col_x == c1_x - ONE_X);

  // ---------------- stage 1: operands ----------------
  logic [SB-1:0]         op_up_r, op_dn_r, op_lt_r, op_rt_r;
  logic [INDEX_BITS-1:0] s1_row_r, s1_col_r;
  logic                  s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= accept && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && accept && hit) begin
      op_up_r   <= older_rd_r;
      op_dn_r   <= sample;
      op_lt_r   <= win0_new;
      op_rt_r   <= win2_new;
      s1_row_r  <= INDEX_BITS'(row_m1_x);
      s1_col_r  <= INDEX_BITS'(col_r);
      s1_last_r <= last_hit;
    end
  end

  // ---------------- stage 2: sum and floor shift ----------------
  logic [SUMW-1:0]       sum;
  logic [SB-1:0]         avg_r;
  logic [INDEX_BITS-1:0] out_row_r, out_col_r;
  logic                  out_last_r;

  assign sum = {{2{op_up_r[SB-1]}}, op_up_r} + {{2{op_dn_r[SB-1]}}, op_dn_r}
             + {{2{op_lt_r[SB-1]}}, op_lt_r} + {{2{op_rt_r[SB-1]}}, op_rt_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      avg_r      <= sum[SUMW-1:2];  // arithmetic shift by two, floor
      out_row_r  <= s1_row_r;
      out_col_r  <= s1_col_r;
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = OUT_W'({out_col_r, out_row_r, avg_r});

endmodule

FILE: test/tb_jacobi_stencil_average_top.sv
// Self-checking testbench for the four-point Jacobi stencil stream block.
`timescale 1ns / 100ps

module tb_jacobi_stencil_average_top;
  import jsa_pkg::*;

  localparam int MAX_COLUMNS = MAX_COLUMNS_DEF;
  localparam int MAX_ROWS    = MAX_ROWS_DEF;
  localparam int SBITS       = SAMPLE_BITS_DEF;
  localparam int IN_W        = ((SBITS + 7) / 8) * 8;
  localparam int OUT_W       = ((SBITS + 20 + 7) / 8) * 8;

  // out_tdata layout, lowest bit up: average, row_index, col_index
  localparam int ROW_LSB = SBITS;
  localparam int COL_LSB = SBITS + INDEX_BITS;

  localparam logic [SBITS-1:0] SAMPLE_MAX = 32'h7FFF_FFFF;
  localparam logic [SBITS-1:0] SAMPLE_MIN = 32'h8000_0000;

  // indexes with no register behind them; the block must ignore them
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_7 = 3'd7;

  localparam int RANDOM_ITEMS = 650;
  // a result leaves through the operand and sum registers; a word that causes
  // no result may still be in flight when the last expected one arrives
  localparam int SETTLE_CYCLES = 8;
  // longest quiet stretch of a correct run: the clearing pass, the longest idle
  // gap on either side and the pipeline; taken many times over
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [SBITS-1:0]      average;
    logic [INDEX_BITS-1:0] row_index;
    logic [INDEX_BITS-1:0] col_index;
    logic                  last_point;
  } point_result_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic [IN_W-1:0]         in_tdata = '0;
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [OUT_W-1:0]        out_tdata;
  logic                    out_tlast;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [GRID_BITS-1:0]    cfg_data = '0;

  jacobi_stencil_average_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Stencil predictor: own copy of registers, line stores and window
  // ---------------------------------------------------------------------------
  int reg_width, reg_height, reg_row_lo, reg_row_hi, reg_col_lo, reg_col_hi;
  logic [SBITS-1:0] upper_line [MAX_COLUMNS];  // row two above the incoming word
  logic [SBITS-1:0] lower_line [MAX_COLUMNS];  // row just above the incoming word
  logic [SBITS-1:0] mid_win [3];               // middle row at columns c-1, c, c+1
  int pos_row, pos_col;                        // position of the next word

  point_result_t expected_points [$];
  logic [SBITS-1:0] pending_samples [$];

  int  mismatch_count = 0;
  bit  in_burst = 1'b0;
  bit  out_burst = 1'b0;
  int  in_hold = 0;
  int  out_hold = 0;
  int  idle_cycles = 0;
  point_result_t want_point;

  function automatic int clamp_dim(input int v, input int hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic signed [SBITS+1:0] widen(input logic [SBITS-1:0] v);
    return {{2{v[SBITS-1]}}, v};
  endfunction

  function automatic logic [SBITS-1:0] lower_at(input int idx, input int w);
    if (idx < w && idx < MAX_COLUMNS) return lower_line[idx];
    return '0;
  endfunction

  function automatic void apply_register(input logic [CFG_IDX_BITS-1:0] idx,
                                         input logic [GRID_BITS-1:0] val);
    case (idx)
      REG_GRID_WIDTH:  reg_width  = int'(val);
      REG_GRID_HEIGHT: reg_height = int'(val);
      REG_ROW_FIRST:   reg_row_lo = int'(val[BOUND_BITS-1:0]);
      REG_ROW_END:     reg_row_hi = int'(val[BOUND_BITS-1:0]);
      REG_COL_FIRST:   reg_col_lo = int'(val[BOUND_BITS-1:0]);
      REG_COL_END:     reg_col_hi = int'(val[BOUND_BITS-1:0]);
      default: ;
    endcase
  endfunction

  // Takes one accepted word; queues the averaged point it completes, if any.
  function automatic void stencil_step(input logic [SBITS-1:0] smp);
    int w, h, r0, r1, c0, c1, r, c;
    logic signed [SBITS+1:0] acc;
    point_result_t pt;
    w  = clamp_dim(reg_width, MAX_COLUMNS);
    h  = clamp_dim(reg_height, MAX_ROWS);
    r0 = (reg_row_lo < 1) ? 1 : reg_row_lo;
    r1 = (reg_row_hi < h - 1) ? reg_row_hi : h - 1;
    c0 = (reg_col_lo < 1) ? 1 : reg_col_lo;
    c1 = (reg_col_hi < w - 1) ? reg_col_hi : w - 1;
    r  = pos_row;
    c  = pos_col;
    if (c >= MAX_COLUMNS) c = 0;

    if (c == 0) begin
      mid_win[0] = '0;
      mid_win[1] = lower_at(0, w);
      mid_win[2] = lower_at(1, w);
    end else begin
      mid_win[0] = mid_win[1];
      mid_win[1] = mid_win[2];
      mid_win[2] = lower_at(c + 1, w);
    end

    // the point one row up is now complete
    if (r >= 1 && r - 1 >= r0 && r - 1 < r1 && c >= c0 && c < c1) begin
      acc = widen(upper_line[c]) + widen(smp) + widen(mid_win[0]) + widen(mid_win[2]);
      acc = acc >>> 2;  // floor division by four
      pt.average    = acc[SBITS-1:0];
      pt.row_index  = INDEX_BITS'(r - 1);
      pt.col_index  = INDEX_BITS'(c);
      pt.last_point = (r == r1 && c == c1 - 1);
      expected_points.push_back(pt);
    end

    upper_line[c] = mid_win[1];
    lower_line[c] = smp;

    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    if (r >= h) r = 0;
    pos_col = c;
    pos_row = r;
  endfunction

  // words still needed before the counters sit at the top left of a frame
  function automatic int steps_to_frame_start(input int w, input int h);
    int r, c, n;
    r = pos_row;
    c = pos_col;
    n = 0;
    while ((r != 0 || c != 0) && n < (1 << 20)) begin
      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) r = 0;
      end
      if (r >= h) r = 0;
      n++;
    end
    return n;
  endfunction

  // gap length: mostly none or short, now and then long
  function automatic int idle_gap(input bit burst);
    int p;
    if (burst) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 88) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // random content, weighted towards the ends of the range and near zero
  function automatic logic [SBITS-1:0] pick_sample();
    int p;
    p = $urandom_range(0, 19);
    if (p < 10) return $urandom;
    if (p < 13) return SAMPLE_MAX;
    if (p < 16) return SAMPLE_MIN;
    return SBITS'($urandom_range(0, 16)) - SBITS'(8);
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: one word from the pending queue per handshake
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_hold = 0;
    end else begin
      if (in_tvalid && in_tready) stencil_step(in_tdata[SBITS-1:0]);
      if (!in_tvalid || in_tready) begin
        if (in_hold > 0) begin
          in_hold--;
          in_tvalid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          in_tdata  <= IN_W'(pending_samples.pop_front());
          in_tvalid <= 1'b1;
          in_hold = idle_gap(in_burst);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: each accepted word against the oldest expected point
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_points.size() == 0) begin
          $error("unexpected result word: tdata %h tlast %b", out_tdata, out_tlast);
          mismatch_count++;
        end else begin
          want_point = expected_points.pop_front();
          if (out_tdata[SBITS-1:0] !== want_point.average) begin
            $error("average: expected %h, got %h", want_point.average,
                   out_tdata[SBITS-1:0]);
            mismatch_count++;
          end
          if (out_tdata[ROW_LSB +: INDEX_BITS] !== want_point.row_index) begin
            $error("row_index: expected %0d, got %0d", want_point.row_index,
                   out_tdata[ROW_LSB +: INDEX_BITS]);
            mismatch_count++;
          end
          if (out_tdata[COL_LSB +: INDEX_BITS] !== want_point.col_index) begin
            $error("col_index: expected %0d, got %0d", want_point.col_index,
                   out_tdata[COL_LSB +: INDEX_BITS]);
            mismatch_count++;
          end
          if (out_tlast !== want_point.last_point) begin
            $error("last_point: expected %b, got %b", want_point.last_point, out_tlast);
            mismatch_count++;
          end
        end
      end
      if (out_hold > 0) begin
        out_hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        out_hold = idle_gap(out_burst);
      end
    end
  end

  // Watchdog: too long without any word moving on any channel
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
                 (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[jacobi_stencil_average_top] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [GRID_BITS-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_register(idx, val);
  endtask

  task automatic set_window(input int w, input int h, input int rf, input int re,
                            input int cf, input int ce);
    write_reg(REG_GRID_WIDTH,  GRID_BITS'(w));
    write_reg(REG_GRID_HEIGHT, GRID_BITS'(h));
    write_reg(REG_ROW_FIRST,   GRID_BITS'(rf));
    write_reg(REG_ROW_END,     GRID_BITS'(re));
    write_reg(REG_COL_FIRST,   GRID_BITS'(cf));
    write_reg(REG_COL_END,     GRID_BITS'(ce));
  endtask

  // window bounds: mostly the whole interior, some inside or past the grid,
  // some raw register values (empty and inverted windows among them)
  task automatic pick_bounds(input int dim, output int lo, output int hi);
    int mode;
    mode = $urandom_range(0, 19);
    if (mode < 12) begin
      lo = 1;
      hi = 1023;
    end else if (mode < 17) begin
      lo = $urandom_range(0, dim);
      hi = $urandom_range(0, dim + 1);
    end else begin
      lo = $urandom_range(0, 2047);
      hi = $urandom_range(0, 2047);
    end
  endtask

  // idle: every word taken, every point seen, pipeline given time to empty
  task automatic drain();
    while (pending_samples.size() != 0 || in_tvalid || expected_points.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int w, h, rf, re, cf, ce, cw, ch, n, mode, rand_items;
    bit neighbour;
    logic [SBITS-1:0] v;

    reg_width  = int'(GRID_WIDTH_RST);
    reg_height = int'(GRID_HEIGHT_RST);
    reg_row_lo = int'(ROW_FIRST_RST);
    reg_row_hi = int'(ROW_END_RST);
    reg_col_lo = int'(COL_FIRST_RST);
    reg_col_hi = int'(COL_END_RST);
    for (int i = 0; i < MAX_COLUMNS; i++) begin
      upper_line[i] = '0;
      lower_line[i] = '0;
    end
    for (int i = 0; i < 3; i++) mid_win[i] = '0;
    pos_row = 0;
    pos_col = 0;
    rand_items = 0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: 3x3 frames, the single interior point (1,1) each time.
    // Written during the clearing pass, which must still take configuration.
    set_window(3, 3, 1, 1023, 1, 1023);
    for (int f = 0; f < 3; f++) begin
      for (int i = 0; i < 9; i++) begin
        neighbour = (i % 2 == 1);  // raster slots 1, 3, 5, 7 surround the centre
        case (f)
          0: v = neighbour ? SAMPLE_MAX : SAMPLE_MIN;  // largest mean
          1: v = neighbour ? SAMPLE_MIN : SAMPLE_MAX;  // smallest mean
          default: v = (i == 1) ? '1 : '0;             // -1/4 floors to -1
        endcase
        pending_samples.push_back(v);
      end
    end
    drain();

    // unused indexes must leave the window alone; two rows of the 3x3 grid
    // bring the counters to the start of its third row
    write_reg(REG_SPARE_6, '1);
    write_reg(REG_SPARE_7, '0);
    repeat (6) pending_samples.push_back(pick_sample());
    drain();

    // Width past the top clamps to MAX_COLUMNS; from the start of the third row
    // one whole row gives points along the middle row, then the counters wrap.
    set_window(2047, 3, 1, 1023, $urandom_range(1, 20), 2047);
    repeat (MAX_COLUMNS + $urandom_range(2, 40))
      pending_samples.push_back(pick_sample());

    // Random phases: new window each time, mostly whole frames from the top left,
    // the rest broken runs that leave the counters mid-frame for the next grid.
    while (rand_items < RANDOM_ITEMS) begin
      drain();
      in_burst  = ($urandom_range(0, 3) == 0);
      out_burst = ($urandom_range(0, 3) == 0);
      mode = $urandom_range(0, 9);
      if (mode == 0) w = $urandom_range(0, 2);
      else if (mode == 1) w = $urandom_range(13, 40);
      else w = $urandom_range(3, 12);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
      cw = clamp_dim(w, MAX_COLUMNS);
      ch = clamp_dim(h, MAX_ROWS);
      pick_bounds(ch, rf, re);
      pick_bounds(cw, cf, ce);
      set_window(w, h, rf, re, cf, ce);
      if ($urandom_range(0, 9) == 0) write_reg(REG_SPARE_6, GRID_BITS'($urandom));
      if ($urandom_range(0, 3) != 0)
        n = steps_to_frame_start(cw, ch) + cw * ch * $urandom_range(1, 3);
      else
        n = $urandom_range(1, 3 * cw * ch);
      repeat (n) pending_samples.push_back(pick_sample());
      rand_items += n;
    end

    drain();
    if (mismatch_count == 0) begin
      $display("[jacobi_stencil_average_top] OK");
    end else begin
      $display("[jacobi_stencil_average_top] ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
design/jsa_pkg.sv
design/jacobi_stencil_average_top.sv
test/tb_jacobi_stencil_average_top.sv
